FILE: hw/rtl/c2wf_pkg.sv
package c2wf_pkg;

  localparam int unsigned MaxCn = 4;
  localparam int unsigned PixMax = 255;

  typedef enum logic [1:0] {
    CfgKernelSize = 2'd0,
    CfgChannels   = 2'd1,
    CfgRowPixels  = 2'd2,
    CfgDelta      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KindPixel = 1'b0,
    KindCoef  = 1'b1
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic       row_last;
  } c2wf_ctrl_t;

endpackage

FILE: hw/rtl/conv2d_u8_window_filter_unit.sv
// Streaming 2-D convolution over an already padded 8-bit image, one element per item,
// with 1 to 4 interleaved channels. Sustains one item per clock while the output register
// is free or being taken. On the way to a result, the line stores (one RAM per stored
// row, registered read) and the tap window come first, then a snapshot of taps and
// coefficients, then a chain of multiply-accumulate cells, one per tap, adds one product
// per cell, and the output register takes the rounded, saturated sum.
// The pipeline advances whenever the output register is free or being taken.
// Coefficient items pass through the chain as bubbles and give no result.
module conv2d_u8_window_filter_unit #(
  parameter int unsigned MAX_K          = 5,
  parameter int unsigned MAX_ROW_ELEMS  = 4096,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel[7:0], coef_index[12:8], coef_value[28:13]
  input  logic [1:0]  s_axis_tuser,  // kind[0], frame_start[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // filtered[7:0]
  output logic        m_axis_tlast,  // row_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned NTap  = MAX_K * MAX_K;
  localparam int unsigned WinW  = (MAX_K - 1) * c2wf_pkg::MaxCn + 1;
  localparam int unsigned ColW  = $clog2(MAX_ROW_ELEMS + 1);
  localparam int unsigned AddrW = $clog2(MAX_ROW_ELEMS);
  localparam int unsigned KW    = $clog2(MAX_K + 1);
  localparam int unsigned TapW  = $clog2(NTap + 1);
  localparam int unsigned AccW  = 40;
  localparam int unsigned NLine = (MAX_K > 1) ? MAX_K - 1 : 1;

  logic [2:0]  kernel_size_q;
  logic [2:0]  channels_q;
  logic [9:0]  row_pixels_q;
  logic [23:0] delta_q;

  logic [4:0]         in_cidx;
  logic signed [15:0] in_cval;
  logic [7:0]         in_pix;
  logic               in_kind, in_fs;
  assign in_pix  = s_axis_tdata[7:0];
  assign in_cidx = s_axis_tdata[12:8];
  assign in_cval = s_axis_tdata[28:13];
  assign in_kind = s_axis_tuser[0];
  assign in_fs   = s_axis_tuser[1];

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o = 1'b1;

  logic acc_in;
  assign acc_in = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_size_q <= 3'd3;
      channels_q    <= 3'd1;
      row_pixels_q  <= 10'd640;
      delta_q       <= '0;
    end else if (cfg_valid_i) begin
      case (c2wf_pkg::cfg_idx_e'(cfg_index_i))
        c2wf_pkg::CfgKernelSize: kernel_size_q <= cfg_data_i[2:0];
        c2wf_pkg::CfgChannels:   channels_q    <= cfg_data_i[2:0];
        c2wf_pkg::CfgRowPixels:  row_pixels_q  <= cfg_data_i[9:0];
        c2wf_pkg::CfgDelta:      delta_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [KW-1:0] k_eff;
  logic [2:0]    cn_eff;
  logic [ColW+2:0] len_full;
  logic [ColW-1:0] len;
  always_comb begin
    k_eff = (kernel_size_q == 3'd0) ? KW'(1) :
            ({1'b0, kernel_size_q} > 4'(MAX_K)) ? KW'(MAX_K) : KW'(kernel_size_q);
    cn_eff = (channels_q == 3'd0) ? 3'd1 : (channels_q > 3'd4) ? 3'd4 : channels_q;
    len_full = (ColW+3)'(((row_pixels_q == 10'd0) ? 11'd1 : {1'b0, row_pixels_q})
               + 11'(k_eff) - 11'd1) * (ColW+3)'(cn_eff);
    len = (len_full > (ColW+3)'(MAX_ROW_ELEMS)) ? ColW'(MAX_ROW_ELEMS) : len_full[ColW-1:0];
  end

  // stage A: position, RAM read address
  logic [ColW-1:0] col_q, col_d, c_cur;
  logic [2:0]      rows_q, rows_d, rows_cur;
  logic            emit_a, last_a;
  always_comb begin
    c_cur = (col_q >= len) ? '0 : col_q;
    rows_cur = rows_q;
    if (in_fs) begin
      c_cur = '0;
      rows_cur = '0;
    end
    emit_a = ({1'b0, rows_cur} >= 4'(k_eff - 1'b1)) &&
             ((ColW+3)'(c_cur) >= (ColW+3)'(k_eff - 1'b1) * (ColW+3)'(cn_eff));
    last_a = (c_cur == len - 1'b1);
    col_d = last_a ? '0 : c_cur + 1'b1;
    rows_d = (last_a && ({1'b0, rows_cur} < 4'(k_eff))) ? rows_cur + 1'b1 : rows_cur;
  end

  logic signed [15:0] coef_q [NTap];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      rows_q <= '0;
      for (int i = 0; i < NTap; i++) coef_q[i] <= '0;
    end else if (acc_in) begin
      if (in_kind == c2wf_pkg::KindCoef) begin
        if (32'(in_cidx) < NTap) coef_q[in_cidx[TapW-1:0]] <= in_cval;
      end else begin
        col_q  <= col_d;
        rows_q <= rows_d;
      end
    end
  end

  // stage B/C pipeline around the RAM read
  logic             vb_q, lb_q, vc_q, lc_q, pb_q;
  logic [7:0]       pixb_q;
  logic [AddrW-1:0] ab_q;
  logic [7:0]       rd [NLine];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0; vc_q <= 1'b0; pb_q <= 1'b0; lb_q <= 1'b0; lc_q <= 1'b0;
    end else if (adv) begin
      pb_q <= acc_in && (in_kind == c2wf_pkg::KindPixel);
      vb_q <= acc_in && (in_kind == c2wf_pkg::KindPixel) && emit_a;
      lb_q <= last_a;
      vc_q <= vb_q;
      lc_q <= lb_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixb_q <= in_pix;
      ab_q   <= c_cur[AddrW-1:0];
    end
  end

  // read in A (address c_cur), data valid in B; write at B
  for (genvar d = 0; d < NLine; d++) begin : g_line
    logic [7:0] wd;
    logic [7:0] rdat;
    assign wd = (d == 0) ? pixb_q : rd[(d == 0) ? 0 : d - 1];
    c2wf_ram #(.Width(8), .Depth(MAX_ROW_ELEMS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (adv && pb_q && (32'(d) + 1 < 32'(k_eff))),
      .waddr_i (ab_q),
      .wdata_i (wd),
      .raddr_i (adv ? c_cur[AddrW-1:0] : ab_q),
      .rdata_o (rdat)
    );
    assign rd[d] = rdat;
  end

  // tap window shifts at stage B (after reads)
  logic [7:0] win_q [MAX_K][WinW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_K; r++)
        for (int t = 0; t < WinW; t++) win_q[r][t] <= '0;
    end else if (adv && pb_q) begin
      for (int r = 0; r < MAX_K; r++) begin
        for (int t = WinW - 1; t > 0; t--) win_q[r][t] <= win_q[r][t-1];
        win_q[r][0] <= (32'(r) < 32'(k_eff)) ? ((r == 0) ? pixb_q : rd[(r == 0) ? 0 : r - 1])
                                             : 8'd0;
      end
    end
  end

  // hold the coefficients seen by the item leaving stage B
  logic signed [15:0] cfc_q [NTap];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NTap; i++) cfc_q[i] <= coef_q[i];
    end
  end

  // snapshot taps for this window at stage C (window holds the new item now)
  logic [7:0]         tap_c [NTap];
  logic signed [15:0] tcoef [NTap];
  always_comb begin
    for (int i = 0; i < NTap; i++) begin
      tap_c[i] = '0;
      tcoef[i] = '0;
    end
    for (int n = 0; n < MAX_K; n++)
      for (int m = 0; m < MAX_K; m++)
        if (32'(n) < 32'(k_eff) && 32'(m) < 32'(k_eff)) begin
          tap_c[n*MAX_K+m] = win_q[32'(k_eff) - 1 - n][(32'(k_eff) - 1 - m) * 32'(cn_eff)];
          tcoef[n*MAX_K+m] = cfc_q[n * 32'(k_eff) + m];
        end
  end

  // chain: per stage a pipeline of taps and coefficients plus accumulator
  logic [7:0]             tp_q [NTap][NTap];
  logic signed [15:0]     tc_q [NTap][NTap];
  logic signed [AccW-1:0] acc [NTap+1];
  c2wf_pkg::c2wf_ctrl_t   ctl_q [NTap+1];

  assign acc[0] = AccW'($signed(delta_q));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NTap; s++) ctl_q[s] <= '0;
    end else if (adv) begin
      ctl_q[0] <= '{valid: vc_q, row_last: lc_q};
      for (int s = 1; s <= NTap; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NTap; i++) begin
        tp_q[0][i] <= tap_c[i];
        tc_q[0][i] <= tcoef[i];
      end
      for (int s = 1; s < NTap; s++)
        for (int i = 0; i < NTap; i++) begin
          tp_q[s][i] <= tp_q[s-1][i];
          tc_q[s][i] <= tc_q[s-1][i];
        end
    end
  end

  logic signed [AccW-1:0] acc0_q;
  always_ff @(posedge clk_i) if (adv) acc0_q <= acc[0];

  logic signed [AccW-1:0] chain [NTap+1];
  assign chain[0] = acc0_q;
  for (genvar s = 0; s < NTap; s++) begin : g_cell
    c2wf_cell #(.AccW(AccW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .pix_i  (tp_q[s][s]),
      .coef_i (tc_q[s][s]),
      .acc_i  (chain[s]),
      .acc_o  (chain[s+1])
    );
    assign acc[s+1] = chain[s+1];
  end

  // round half even and saturate
  logic signed [AccW-1:0] s_fin;
  logic [COEF_FRAC_BITS-1:0] fr;
  logic signed [AccW-COEF_FRAC_BITS-1:0] q;
  logic [7:0] res;
  always_comb begin
    s_fin = acc[NTap];
    fr = s_fin[COEF_FRAC_BITS-1:0];
    q = s_fin[AccW-1:COEF_FRAC_BITS];
    if (fr > {1'b1, {(COEF_FRAC_BITS-1){1'b0}}} ||
        (fr == {1'b1, {(COEF_FRAC_BITS-1){1'b0}}} && q[0])) q = q + 1'b1;
    if (q < 0) res = 8'd0;
    else if (q > (AccW-COEF_FRAC_BITS)'(c2wf_pkg::PixMax)) res = 8'(c2wf_pkg::PixMax);
    else res = q[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= ctl_q[NTap].valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= res;
      m_axis_tlast <= ctl_q[NTap].row_last;
    end
  end

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready)) else $error("ready");
`endif

endmodule

FILE: hw/rtl/c2wf_ram.sv
module c2wf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/c2wf_cell.sv
module c2wf_cell #(
  parameter int unsigned AccW = 40
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [7:0]             pix_i,
  input  logic signed [15:0]     coef_i,
  input  logic signed [AccW-1:0] acc_i,
  output logic signed [AccW-1:0] acc_o
);

  logic signed [24:0] prod_d;

  assign prod_d = coef_i * $signed({1'b0, pix_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o <= acc_i + AccW'(prod_d);
    end
  end

endmodule
